### hdl/tts_pkg.sv
package tts_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned OFS_W  = 16;

	// Register indexes of the configuration port.
	localparam logic REG_SEARCH_MODE  = 1'b0;
	localparam logic REG_START_OFFSET = 1'b1;

	// Search modes.
	localparam logic [1:0] MODE_CALL_OPEN  = 2'd0;
	localparam logic [1:0] MODE_CALL_CLOSE = 2'd1;
	localparam logic [1:0] MODE_WORD       = 2'd2;
	localparam logic [1:0] MODE_CMP        = 2'd3;

	// Operator kinds reported in the result.
	localparam logic [2:0] OP_NONE = 3'd0;
	localparam logic [2:0] OP_EQ   = 3'd1;
	localparam logic [2:0] OP_NE   = 3'd2;
	localparam logic [2:0] OP_LT   = 3'd3;
	localparam logic [2:0] OP_LE   = 3'd4;
	localparam logic [2:0] OP_GT   = 3'd5;
	localparam logic [2:0] OP_GE   = 3'd6;
	localparam logic [2:0] OP_WORD = 3'd7;

	// Characters the scanner cares about.
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_A      = 8'h61;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_D      = 8'h64;
	localparam logic [7:0] CH_O      = 8'h6F;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_USCORE = 8'h5F;

	typedef enum logic [1:0] {
		QUOTE_NONE   = 2'd0,
		QUOTE_SINGLE = 2'd1,
		QUOTE_DOUBLE = 2'd2
	} quote_t;

	typedef enum logic [2:0] {
		CAND_NONE = 3'd0,
		CAND_EQ   = 3'd1,
		CAND_BANG = 3'd2,
		CAND_LT   = 3'd3,
		CAND_GT   = 3'd4
	} cand_t;

	typedef enum logic [2:0] {
		WORD_NONE = 3'd0,
		WORD_A    = 3'd1,
		WORD_AN   = 3'd2,
		WORD_AND  = 3'd3,
		WORD_O    = 3'd4,
		WORD_OR   = 3'd5
	} word_t;

	typedef struct packed {
		logic [BYTE_W-1:0] char_byte;
		logic              last_byte;
	} in_word_t;

	typedef struct packed {
		logic             found;
		logic [OFS_W-1:0] match_pos;
		logic [2:0]       operator_kind;
		logic             word_is_or;
	} result_t;

	function automatic logic is_ident(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
			(c >= 8'h30 && c <= 8'h39) || c == CH_USCORE;
	endfunction

endpackage

### hdl/top_level_token_scanner.sv
// Scans expression text one byte per word and returns one result word after
// the word flagged with tlast: whether the selected search (call open paren,
// balancing close paren, top-level "and"/"or", or top-level comparison
// operator) matched, its byte position, the operator kind and the and/or flag.
// Quoted spans with backslash escapes are skipped and bracket depth is
// tracked. A byte is taken every cycle; it is held in the input register
// and updates the scan state when it moves on, which for a last byte also
// loads the result register. Input stalls only while a last byte waits on
// a result that has not yet been taken. Configuration must be written only
// while no text is in flight; the block itself does not enforce it. It
// applies from the next byte.
module top_level_token_scanner #(
	parameter int unsigned POS_BITS   = 16,
	parameter int unsigned DEPTH_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_byte
	input  logic        s_tlast,   // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [0] found, [16:1] match_pos, [19:17] operator_kind,
	                               // [20] word_is_or, [23:21] zero
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_wdata
);

	logic [1:0]                    search_mode_q;
	logic [tts_pkg::OFS_W-1:0]     start_offset_q;
	logic                          s1_valid, advance;
	tts_pkg::in_word_t             in_word, s1_word;
	tts_pkg::result_t              scan_result, out_result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			search_mode_q  <= tts_pkg::MODE_CALL_OPEN;
			start_offset_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tts_pkg::REG_SEARCH_MODE:  search_mode_q  <= cfg_wdata[1:0];
				tts_pkg::REG_START_OFFSET: start_offset_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign in_word.char_byte = s_tdata;
	assign in_word.last_byte = s_tlast;

	// A last byte waits in the input register while the result register is full and not being taken.
	assign advance = s1_valid && (!s1_word.last_byte || !m_tvalid || m_tready);

	tts_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_word  (in_word),
		.advance  (advance),
		.s1_valid (s1_valid),
		.s1_word  (s1_word)
	);

	tts_scan #(
		.POS_BITS   (POS_BITS),
		.DEPTH_BITS (DEPTH_BITS)
	) u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance),
		.word         (s1_word),
		.search_mode  (search_mode_q),
		.start_offset (start_offset_q),
		.result       (scan_result)
	);

	tts_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (advance && s1_word.last_byte),
		.result     (scan_result),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_result (out_result)
	);

	assign m_tdata = {3'b000, out_result.word_is_or, out_result.operator_kind,
		out_result.match_pos, out_result.found};

endmodule

### hdl/tts_in_stage.sv
module tts_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  tts_pkg::in_word_t in_word,
	input  logic              advance,
	output logic              s1_valid,
	output tts_pkg::in_word_t s1_word
);

	logic              valid_s1;
	tts_pkg::in_word_t word_s1;

	// The register refills in the same cycle that its word moves on.
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			word_s1 <= in_word;
		end
	end

	assign s1_valid = valid_s1;
	assign s1_word  = word_s1;

endmodule

### hdl/tts_scan.sv
module tts_scan #(
	parameter int unsigned POS_BITS   = 16,
	parameter int unsigned DEPTH_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  tts_pkg::in_word_t            word,
	input  logic [1:0]                   search_mode,
	input  logic [tts_pkg::OFS_W-1:0]    start_offset,
	output tts_pkg::result_t             result
);

	localparam int unsigned CW = (POS_BITS > tts_pkg::OFS_W) ? POS_BITS : tts_pkg::OFS_W;
	localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {1'b0, {(DEPTH_BITS-1){1'b1}}};
	localparam logic [DEPTH_BITS-1:0] DEPTH_MIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};
	localparam logic [POS_BITS-1:0]   POS_MAX   = {POS_BITS{1'b1}};

	logic [DEPTH_BITS-1:0] depth_q, n_depth, depth_inc, depth_dec;
	tts_pkg::quote_t       quote_q, n_quote;
	logic                  esc_q, n_esc;
	logic [POS_BITS-1:0]   pos_q, n_pos, cand_q, n_cand, mat_q, n_mat;
	logic [7:0]            prev_q, n_prev;
	tts_pkg::cand_t        pend_q, n_pend;
	tts_pkg::word_t        wp_q, n_wp, wp_old;
	logic                  latched_q, n_lat;
	logic [2:0]            kind_q, n_kind, pkind;
	logic                  or_q, n_or;
	logic [CW-1:0]         pos_x, off_x, mat_x;
	logic [7:0]            c;

	assign c         = word.char_byte;
	assign depth_inc = (depth_q != DEPTH_MAX) ? depth_q + 1'b1 : depth_q;
	assign depth_dec = (depth_q != DEPTH_MIN) ? depth_q - 1'b1 : depth_q;
	assign pos_x     = CW'(pos_q);
	assign off_x     = CW'(start_offset);

	always_comb begin
		n_depth = depth_q;
		n_quote = quote_q;
		n_esc   = esc_q;
		n_pos   = (pos_q != POS_MAX) ? pos_q + 1'b1 : pos_q;
		n_prev  = c;
		n_pend  = pend_q;
		n_cand  = cand_q;
		n_lat   = latched_q;
		n_wp    = wp_q;
		n_kind  = kind_q;
		n_or    = or_q;
		n_mat   = mat_q;
		pkind   = tts_pkg::OP_NONE;
		wp_old  = tts_pkg::WORD_NONE;
		mat_x   = '0;

		// Lookahead held for another mode is dropped.
		if (search_mode != tts_pkg::MODE_CMP) n_pend = tts_pkg::CAND_NONE;
		if (search_mode != tts_pkg::MODE_WORD) n_wp = tts_pkg::WORD_NONE;

		if (!latched_q) begin
			// Resolve the comparison candidate left by the previous byte.
			if (n_pend != tts_pkg::CAND_NONE) begin
				unique case (n_pend)
					tts_pkg::CAND_EQ:   if (c == tts_pkg::CH_EQ) pkind = tts_pkg::OP_EQ;
					tts_pkg::CAND_BANG: if (c == tts_pkg::CH_EQ) pkind = tts_pkg::OP_NE;
					tts_pkg::CAND_LT:   if (c != tts_pkg::CH_LT)
						pkind = (c == tts_pkg::CH_EQ) ? tts_pkg::OP_LE : tts_pkg::OP_LT;
					tts_pkg::CAND_GT:   if (c != tts_pkg::CH_GT)
						pkind = (c == tts_pkg::CH_EQ) ? tts_pkg::OP_GE : tts_pkg::OP_GT;
					default: pkind = tts_pkg::OP_NONE;
				endcase
				n_pend = tts_pkg::CAND_NONE;
				if (pkind != tts_pkg::OP_NONE) begin
					n_lat  = 1'b1;
					n_mat  = cand_q;
					n_kind = pkind;
					n_or   = 1'b0;
					n_wp   = tts_pkg::WORD_NONE;
				end
			end

			// Advance a partly seen logical word.
			if (n_wp != tts_pkg::WORD_NONE) begin
				wp_old = n_wp;
				n_wp   = tts_pkg::WORD_NONE;
				if (wp_old == tts_pkg::WORD_A && c == tts_pkg::CH_N) begin
					n_wp = tts_pkg::WORD_AN;
				end else if (wp_old == tts_pkg::WORD_AN && c == tts_pkg::CH_D) begin
					n_wp = tts_pkg::WORD_AND;
				end else if (wp_old == tts_pkg::WORD_O && c == tts_pkg::CH_R) begin
					n_wp = tts_pkg::WORD_OR;
				end else if ((wp_old == tts_pkg::WORD_AND || wp_old == tts_pkg::WORD_OR) &&
					!tts_pkg::is_ident(c)) begin
					n_lat  = 1'b1;
					n_mat  = cand_q;
					n_kind = tts_pkg::OP_WORD;
					n_or   = (wp_old == tts_pkg::WORD_OR);
					n_pend = tts_pkg::CAND_NONE;
				end
			end

			if (!n_lat && pos_x >= off_x) begin
				if (quote_q != tts_pkg::QUOTE_NONE) begin
					if (esc_q) begin
						n_esc = 1'b0;
					end else if (c == tts_pkg::CH_BSLASH) begin
						n_esc = 1'b1;
					end else if ((quote_q == tts_pkg::QUOTE_SINGLE && c == tts_pkg::CH_SQUOTE) ||
						(quote_q == tts_pkg::QUOTE_DOUBLE && c == tts_pkg::CH_DQUOTE)) begin
						n_quote = tts_pkg::QUOTE_NONE;
					end
				end else if (c == tts_pkg::CH_DQUOTE) begin
					n_quote = tts_pkg::QUOTE_DOUBLE;
				end else if (c == tts_pkg::CH_SQUOTE) begin
					n_quote = tts_pkg::QUOTE_SINGLE;
				end else if (search_mode == tts_pkg::MODE_CALL_CLOSE) begin
					// Only parens count here; the balancing close ends the search.
					if (c == tts_pkg::CH_LPAREN) begin
						n_depth = depth_inc;
					end else if (c == tts_pkg::CH_RPAREN) begin
						n_depth = depth_dec;
						if (depth_dec == '0) begin
							n_lat  = 1'b1;
							n_mat  = pos_q;
							n_kind = tts_pkg::OP_NONE;
							n_or   = 1'b0;
							n_pend = tts_pkg::CAND_NONE;
							n_wp   = tts_pkg::WORD_NONE;
						end
					end
				end else if (search_mode == tts_pkg::MODE_CALL_OPEN && c == tts_pkg::CH_LPAREN &&
					depth_q == '0) begin
					n_lat  = 1'b1;
					n_mat  = pos_q;
					n_kind = tts_pkg::OP_NONE;
					n_or   = 1'b0;
					n_pend = tts_pkg::CAND_NONE;
					n_wp   = tts_pkg::WORD_NONE;
				end else if (c == tts_pkg::CH_LPAREN || c == tts_pkg::CH_LBRACK ||
					c == tts_pkg::CH_LBRACE) begin
					n_depth = depth_inc;
				end else if (c == tts_pkg::CH_RPAREN || c == tts_pkg::CH_RBRACK ||
					c == tts_pkg::CH_RBRACE) begin
					n_depth = depth_dec;
				end else if (depth_q == '0) begin
					if (search_mode == tts_pkg::MODE_WORD) begin
						if ((c == tts_pkg::CH_A || c == tts_pkg::CH_O) &&
							!tts_pkg::is_ident(prev_q)) begin
							n_wp   = (c == tts_pkg::CH_A) ? tts_pkg::WORD_A : tts_pkg::WORD_O;
							n_cand = pos_q;
						end
					end else if (search_mode == tts_pkg::MODE_CMP) begin
						if (c == tts_pkg::CH_EQ) begin
							n_pend = tts_pkg::CAND_EQ;
							n_cand = pos_q;
						end else if (c == tts_pkg::CH_BANG) begin
							n_pend = tts_pkg::CAND_BANG;
							n_cand = pos_q;
						end else if (c == tts_pkg::CH_LT && prev_q != tts_pkg::CH_LT) begin
							n_pend = tts_pkg::CAND_LT;
							n_cand = pos_q;
						end else if (c == tts_pkg::CH_GT && prev_q != tts_pkg::CH_GT) begin
							n_pend = tts_pkg::CAND_GT;
							n_cand = pos_q;
						end
					end
				end
			end
		end

		// At the end of the text a lone < or > or a complete word still counts.
		if (word.last_byte && !n_lat) begin
			if (n_pend == tts_pkg::CAND_LT) begin
				n_lat  = 1'b1;
				n_mat  = n_cand;
				n_kind = tts_pkg::OP_LT;
				n_or   = 1'b0;
			end else if (n_pend == tts_pkg::CAND_GT) begin
				n_lat  = 1'b1;
				n_mat  = n_cand;
				n_kind = tts_pkg::OP_GT;
				n_or   = 1'b0;
			end else if (n_wp == tts_pkg::WORD_AND || n_wp == tts_pkg::WORD_OR) begin
				n_lat  = 1'b1;
				n_mat  = n_cand;
				n_kind = tts_pkg::OP_WORD;
				n_or   = (n_wp == tts_pkg::WORD_OR);
			end
		end

		mat_x                = CW'(n_mat);
		result.found         = n_lat;
		result.match_pos     = n_lat ? mat_x[tts_pkg::OFS_W-1:0] : '0;
		result.operator_kind = n_lat ? n_kind : tts_pkg::OP_NONE;
		result.word_is_or    = n_lat & n_or;

		if (word.last_byte) begin
			n_depth = '0;
			n_quote = tts_pkg::QUOTE_NONE;
			n_esc   = 1'b0;
			n_pos   = '0;
			n_prev  = '0;
			n_pend  = tts_pkg::CAND_NONE;
			n_cand  = '0;
			n_lat   = 1'b0;
			n_wp    = tts_pkg::WORD_NONE;
			n_kind  = tts_pkg::OP_NONE;
			n_or    = 1'b0;
			n_mat   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q   <= '0;
			quote_q   <= tts_pkg::QUOTE_NONE;
			esc_q     <= 1'b0;
			pos_q     <= '0;
			prev_q    <= '0;
			pend_q    <= tts_pkg::CAND_NONE;
			cand_q    <= '0;
			latched_q <= 1'b0;
			wp_q      <= tts_pkg::WORD_NONE;
			kind_q    <= tts_pkg::OP_NONE;
			or_q      <= 1'b0;
			mat_q     <= '0;
		end else if (step) begin
			depth_q   <= n_depth;
			quote_q   <= n_quote;
			esc_q     <= n_esc;
			pos_q     <= n_pos;
			prev_q    <= n_prev;
			pend_q    <= n_pend;
			cand_q    <= n_cand;
			latched_q <= n_lat;
			wp_q      <= n_wp;
			kind_q    <= n_kind;
			or_q      <= n_or;
			mat_q     <= n_mat;
		end
	end

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		step && word.last_byte |=> pos_q == '0 && !latched_q && depth_q == '0)
		else $error("scan state not cleared after the last word");

	a_escape_in_quote: assert property (@(posedge clk) disable iff (!arst_n)
		esc_q |-> quote_q != tts_pkg::QUOTE_NONE)
		else $error("escape pending outside a quoted span");

	a_latched_no_lookahead: assert property (@(posedge clk) disable iff (!arst_n)
		latched_q |-> pend_q == tts_pkg::CAND_NONE && wp_q == tts_pkg::WORD_NONE)
		else $error("lookahead still held after a match");

endmodule

### hdl/tts_out_stage.sv
module tts_out_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  tts_pkg::result_t result,
	output logic             out_valid,
	input  logic             out_ready,
	output tts_pkg::result_t out_result
);

	logic             valid_q;
	tts_pkg::result_t result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= result;
		end
	end

	assign out_valid  = valid_q;
	assign out_result = result_q;

endmodule

### tb/tb.sv
module tb;

	localparam int POS_W      = 16;
	localparam int DEPTH_W    = 16;
	localparam int LVL_MAX    = 2 ** (DEPTH_W - 1) - 1;
	localparam int LVL_MIN    = -(2 ** (DEPTH_W - 1));
	localparam int RAND_BYTES = 1400;
	localparam int CYCLE_LIMIT = 2000000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        cfg_we;
	logic        cfg_index;
	logic [15:0] cfg_wdata;

	top_level_token_scanner #(
		.POS_BITS(POS_W),
		.DEPTH_BITS(DEPTH_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// Scanner image kept by the testbench.
	logic [1:0]       cfg_mode;
	logic [15:0]      cfg_ofs;
	int               paren_lvl;
	tts_pkg::quote_t  in_quote;
	bit               esc_next;
	logic [POS_W-1:0] cur_pos;
	logic [7:0]       last_ch;
	tts_pkg::cand_t   cmp_cand;
	tts_pkg::word_t   word_st;
	logic [POS_W-1:0] cand_at;
	bit               hit;
	logic [POS_W-1:0] hit_at;
	logic [2:0]       hit_kind;
	bit               hit_or;

	tts_pkg::result_t pending_results[$];

	typedef struct {
		logic [1:0]       mode;
		logic [15:0]      ofs;
		logic [7:0]       fill_a;
		int               n_a;
		logic [7:0]       fill_b;
		int               n_b;
		string            text;
		bit               known;
		tts_pkg::result_t want;
	} text_case_t;

	text_case_t text_cases[$];
	logic [7:0] txt_q[$];
	bit         last_q[$];

	string cmp_ops[10] = '{"==", "!=", "<", "<=", ">", ">=", "<<", ">>", "=", "!"};
	string id_chars = "andorxyz_AZ09q";

	int mismatches = 0;
	int results_seen = 0;
	int bytes_sent = 0;
	int expr_count = 0;
	int hits_seen = 0;
	int burst_left = 0;
	int ready_pct = 100;
	int rx_tick = 0;
	int cycles = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit ident_ch(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
			(c >= "0" && c <= "9") || c == "_";
	endfunction

	task automatic restart_scan();
		paren_lvl = 0;
		in_quote = tts_pkg::QUOTE_NONE;
		esc_next = 1'b0;
		cur_pos = '0;
		last_ch = 8'h00;
		cmp_cand = tts_pkg::CAND_NONE;
		word_st = tts_pkg::WORD_NONE;
		cand_at = '0;
		hit = 1'b0;
		hit_at = '0;
		hit_kind = tts_pkg::OP_NONE;
		hit_or = 1'b0;
	endtask

	task automatic take_hit(input logic [POS_W-1:0] p, input logic [2:0] k, input bit o);
		hit = 1'b1;
		hit_at = p;
		hit_kind = k;
		hit_or = o;
		cmp_cand = tts_pkg::CAND_NONE;
		word_st = tts_pkg::WORD_NONE;
	endtask

	task automatic lvl_up();
		if (paren_lvl < LVL_MAX) paren_lvl++;
	endtask

	task automatic lvl_down();
		if (paren_lvl > LVL_MIN) paren_lvl--;
	endtask

	// Quote, bracket and candidate tracking for one byte at or past the offset.
	task automatic scan_char(input logic [7:0] c, input logic [POS_W-1:0] p);
		if (in_quote != tts_pkg::QUOTE_NONE) begin
			if (esc_next) esc_next = 1'b0;
			else if (c == tts_pkg::CH_BSLASH) esc_next = 1'b1;
			else if ((in_quote == tts_pkg::QUOTE_SINGLE && c == tts_pkg::CH_SQUOTE) ||
				(in_quote == tts_pkg::QUOTE_DOUBLE && c == tts_pkg::CH_DQUOTE))
				in_quote = tts_pkg::QUOTE_NONE;
		end else if (c == tts_pkg::CH_DQUOTE) begin
			in_quote = tts_pkg::QUOTE_DOUBLE;
		end else if (c == tts_pkg::CH_SQUOTE) begin
			in_quote = tts_pkg::QUOTE_SINGLE;
		end else if (cfg_mode == tts_pkg::MODE_CALL_CLOSE) begin
			if (c == tts_pkg::CH_LPAREN) begin
				lvl_up();
			end else if (c == tts_pkg::CH_RPAREN) begin
				lvl_down();
				if (paren_lvl == 0) take_hit(p, tts_pkg::OP_NONE, 1'b0);
			end
		end else if (cfg_mode == tts_pkg::MODE_CALL_OPEN && c == tts_pkg::CH_LPAREN &&
			paren_lvl == 0) begin
			take_hit(p, tts_pkg::OP_NONE, 1'b0);
		end else if (c == tts_pkg::CH_LPAREN || c == tts_pkg::CH_LBRACK ||
			c == tts_pkg::CH_LBRACE) begin
			lvl_up();
		end else if (c == tts_pkg::CH_RPAREN || c == tts_pkg::CH_RBRACK ||
			c == tts_pkg::CH_RBRACE) begin
			lvl_down();
		end else if (paren_lvl == 0) begin
			if (cfg_mode == tts_pkg::MODE_WORD) begin
				if ((c == tts_pkg::CH_A || c == tts_pkg::CH_O) && !ident_ch(last_ch)) begin
					word_st = (c == tts_pkg::CH_A) ? tts_pkg::WORD_A : tts_pkg::WORD_O;
					cand_at = p;
				end
			end else if (cfg_mode == tts_pkg::MODE_CMP) begin
				if (c == tts_pkg::CH_EQ) begin
					cmp_cand = tts_pkg::CAND_EQ;
					cand_at = p;
				end else if (c == tts_pkg::CH_BANG) begin
					cmp_cand = tts_pkg::CAND_BANG;
					cand_at = p;
				end else if (c == tts_pkg::CH_LT && last_ch != tts_pkg::CH_LT) begin
					cmp_cand = tts_pkg::CAND_LT;
					cand_at = p;
				end else if (c == tts_pkg::CH_GT && last_ch != tts_pkg::CH_GT) begin
					cmp_cand = tts_pkg::CAND_GT;
					cand_at = p;
				end
			end
		end
	endtask

	// Advances the scanner image by one accepted word; queues the result on tlast.
	task automatic track_byte(input logic [7:0] c, input bit lst);
		logic [POS_W-1:0] p;
		logic [2:0]       k;
		tts_pkg::cand_t   pc;
		tts_pkg::word_t   w;
		tts_pkg::result_t r;
		p = cur_pos;
		if (cfg_mode != tts_pkg::MODE_CMP) cmp_cand = tts_pkg::CAND_NONE;
		if (cfg_mode != tts_pkg::MODE_WORD) word_st = tts_pkg::WORD_NONE;
		if (!hit) begin
			// The lookahead byte settles the candidate held from the previous word.
			if (cmp_cand != tts_pkg::CAND_NONE) begin
				pc = cmp_cand;
				cmp_cand = tts_pkg::CAND_NONE;
				k = tts_pkg::OP_NONE;
				if (pc == tts_pkg::CAND_EQ && c == tts_pkg::CH_EQ) k = tts_pkg::OP_EQ;
				else if (pc == tts_pkg::CAND_BANG && c == tts_pkg::CH_EQ) k = tts_pkg::OP_NE;
				else if (pc == tts_pkg::CAND_LT && c != tts_pkg::CH_LT)
					k = (c == tts_pkg::CH_EQ) ? tts_pkg::OP_LE : tts_pkg::OP_LT;
				else if (pc == tts_pkg::CAND_GT && c != tts_pkg::CH_GT)
					k = (c == tts_pkg::CH_EQ) ? tts_pkg::OP_GE : tts_pkg::OP_GT;
				if (k != tts_pkg::OP_NONE) take_hit(cand_at, k, 1'b0);
			end
			if (word_st != tts_pkg::WORD_NONE) begin
				w = word_st;
				word_st = tts_pkg::WORD_NONE;
				if (w == tts_pkg::WORD_A && c == tts_pkg::CH_N) word_st = tts_pkg::WORD_AN;
				else if (w == tts_pkg::WORD_AN && c == tts_pkg::CH_D)
					word_st = tts_pkg::WORD_AND;
				else if (w == tts_pkg::WORD_O && c == tts_pkg::CH_R) word_st = tts_pkg::WORD_OR;
				else if ((w == tts_pkg::WORD_AND || w == tts_pkg::WORD_OR) && !ident_ch(c))
					take_hit(cand_at, tts_pkg::OP_WORD, w == tts_pkg::WORD_OR);
			end
			if (!hit && p >= cfg_ofs) scan_char(c, p);
		end
		last_ch = c;
		if (cur_pos != {POS_W{1'b1}}) cur_pos++;
		if (lst) begin
			// End of text stands in for the lookahead byte.
			if (!hit) begin
				if (cmp_cand == tts_pkg::CAND_LT) take_hit(cand_at, tts_pkg::OP_LT, 1'b0);
				else if (cmp_cand == tts_pkg::CAND_GT) take_hit(cand_at, tts_pkg::OP_GT, 1'b0);
				else if (word_st == tts_pkg::WORD_AND) take_hit(cand_at, tts_pkg::OP_WORD, 1'b0);
				else if (word_st == tts_pkg::WORD_OR) take_hit(cand_at, tts_pkg::OP_WORD, 1'b1);
			end
			r.found = hit;
			r.match_pos = hit ? hit_at[15:0] : 16'd0;
			r.operator_kind = hit ? hit_kind : tts_pkg::OP_NONE;
			r.word_is_or = hit ? hit_or : 1'b0;
			pending_results.push_back(r);
			expr_count++;
			if (hit) hits_seen++;
			restart_scan();
		end
	endtask

	task automatic flag_mismatch(input string what, input int got, input int want_v);
		$display("ERROR result %0d %s: got 0x%0h, wanted 0x%0h", results_seen, what, got,
			want_v);
		mismatches++;
	endtask

	task automatic check_result(input logic [23:0] d);
		tts_pkg::result_t want;
		results_seen++;
		if (pending_results.size() == 0) begin
			flag_mismatch("arrived with nothing outstanding", int'(d), 0);
			return;
		end
		want = pending_results.pop_front();
		if (d[0] !== want.found)
			flag_mismatch("found", int'(d[0]), int'(want.found));
		if (d[16:1] !== want.match_pos)
			flag_mismatch("match_pos", int'(d[16:1]), int'(want.match_pos));
		if (d[19:17] !== want.operator_kind)
			flag_mismatch("operator_kind", int'(d[19:17]), int'(want.operator_kind));
		if (d[20] !== want.word_is_or)
			flag_mismatch("word_is_or", int'(d[20]), int'(want.word_is_or));
		if (d[23:21] !== 3'b000) flag_mismatch("pad bits", int'(d[23:21]), 0);
	endtask

	// Receiver: checks each taken word, stalls on a duty cycle that changes now and then.
	always @(posedge clk) begin
		if (m_tvalid === 1'b1 && m_tready) check_result(m_tdata);
		rx_tick++;
		if (rx_tick % 97 == 0) begin
			case ($urandom_range(0, 4))
				0, 1: ready_pct = 100;
				2: ready_pct = 75;
				3: ready_pct = 40;
				default: ready_pct = 10;
			endcase
		end
		m_tready <= ($urandom_range(1, 100) <= ready_pct);
	end

	task automatic send_byte(input logic [7:0] c, input bit lst);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= c;
		s_tlast <= lst;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		track_byte(c, lst);
		bytes_sent++;
	endtask

	task automatic send_queued();
		foreach (txt_q[i]) send_byte(txt_q[i], last_q[i]);
		txt_q.delete();
		last_q.delete();
	endtask

	task automatic add_ch(input logic [7:0] c);
		txt_q.push_back(c);
		last_q.push_back(1'b0);
	endtask

	task automatic add_str(input string s);
		for (int i = 0; i < s.len(); i++) add_ch(s[i]);
	endtask

	// Waits until every outstanding result has been taken and the pipe is empty.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apply_setting(input logic [1:0] mode, input logic [15:0] ofs);
		cfg_we <= 1'b1;
		cfg_index <= tts_pkg::REG_SEARCH_MODE;
		cfg_wdata <= {14'd0, mode};
		@(posedge clk);
		cfg_index <= tts_pkg::REG_START_OFFSET;
		cfg_wdata <= ofs;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_mode = mode;
		cfg_ofs = ofs;
	endtask

	task automatic add_case(input logic [1:0] mode, input logic [15:0] ofs,
		input logic [7:0] fa, input int na, input logic [7:0] fb, input int nb,
		input string text, input bit known, input bit f, input logic [15:0] pos,
		input logic [2:0] kind, input bit o);
		text_case_t t;
		t.mode = mode;
		t.ofs = ofs;
		t.fill_a = fa;
		t.n_a = na;
		t.fill_b = fb;
		t.n_b = nb;
		t.text = text;
		t.known = known;
		t.want.found = f;
		t.want.match_pos = pos;
		t.want.operator_kind = kind;
		t.want.word_is_or = o;
		text_cases.push_back(t);
	endtask

	// One random token: mostly well-formed expression pieces, some raw noise.
	task automatic add_token();
		int n;
		logic [7:0] q;
		case ($urandom_range(0, 12))
			0, 1, 2: begin
				n = $urandom_range(1, 3);
				repeat (n) add_ch(id_chars[$urandom_range(0, id_chars.len() - 1)]);
			end
			3, 4: begin
				if ($urandom_range(0, 1) != 0) add_str("and");
				else add_str("or");
			end
			5: add_str(cmp_ops[$urandom_range(0, 9)]);
			6: begin
				n = $urandom_range(0, 3);
				add_ch(n == 0 ? tts_pkg::CH_LBRACK :
					(n == 1 ? tts_pkg::CH_LBRACE : tts_pkg::CH_LPAREN));
			end
			7: begin
				n = $urandom_range(0, 3);
				add_ch(n == 0 ? tts_pkg::CH_RBRACK :
					(n == 1 ? tts_pkg::CH_RBRACE : tts_pkg::CH_RPAREN));
			end
			8: begin
				q = $urandom_range(0, 1) ? tts_pkg::CH_SQUOTE : tts_pkg::CH_DQUOTE;
				add_ch(q);
				n = $urandom_range(0, 4);
				repeat (n) begin
					case ($urandom_range(0, 4))
						0: add_ch(tts_pkg::CH_BSLASH);
						1: add_ch(tts_pkg::CH_SQUOTE);
						2: add_ch(tts_pkg::CH_DQUOTE);
						3: add_ch(tts_pkg::CH_LPAREN);
						default: add_str("a<");
					endcase
				end
				if ($urandom_range(0, 3) != 0) add_ch(q);
			end
			9, 10: add_str(" ");
			default: add_ch(8'($urandom_range(0, 255)));
		endcase
	endtask

	initial begin
		int rand_start;
		int n_expr;
		int target;
		int first_len;
		int start;
		int r;
		logic [1:0] mode;
		logic [15:0] ofs;
		int lparens[$];

		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= 8'h00;
		s_tlast <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= tts_pkg::REG_SEARCH_MODE;
		cfg_wdata <= 16'd0;
		cfg_mode = tts_pkg::MODE_CALL_OPEN;
		cfg_ofs = 16'd0;
		restart_scan();

		add_case(tts_pkg::MODE_CALL_OPEN, 0, 0, 0, 0, 0, "f(x)", 1, 1, 1, tts_pkg::OP_NONE, 0);
		add_case(tts_pkg::MODE_CALL_OPEN, 0, 0, 0, 0, 0, "\"(\"(", 1, 1, 3,
			tts_pkg::OP_NONE, 0);
		// Depth goes negative, then back to zero for the final paren.
		add_case(tts_pkg::MODE_CALL_OPEN, 0, tts_pkg::CH_RPAREN, 5, tts_pkg::CH_LPAREN, 5,
			"(", 0, 0, 0, 0, 0);
		add_case(tts_pkg::MODE_CALL_OPEN, 2, 0, 0, 0, 0, "((x(", 1, 1, 3, tts_pkg::OP_NONE, 0);
		add_case(tts_pkg::MODE_CALL_OPEN, 16'hFFFF, 0, 0, 0, 0, "f(x)", 1, 0, 0,
			tts_pkg::OP_NONE, 0);
		add_case(tts_pkg::MODE_CALL_CLOSE, 1, 0, 0, 0, 0, "f(a(b))", 1, 1, 6,
			tts_pkg::OP_NONE, 0);
		add_case(tts_pkg::MODE_CALL_CLOSE, 0, 0, 0, 0, 0, ")", 1, 0, 0, tts_pkg::OP_NONE, 0);
		add_case(tts_pkg::MODE_WORD, 0, 0, 0, 0, 0, "x and y", 1, 1, 2, tts_pkg::OP_WORD, 0);
		add_case(tts_pkg::MODE_WORD, 0, 0, 0, 0, 0, "a or", 1, 1, 2, tts_pkg::OP_WORD, 1);
		add_case(tts_pkg::MODE_WORD, 0, "x", 1, 8'hC3, 1, "or ", 1, 1, 2, tts_pkg::OP_WORD, 1);
		add_case(tts_pkg::MODE_WORD, 0, 0, 0, 0, 0, "orb", 1, 0, 0, tts_pkg::OP_NONE, 0);
		// The word counts only once the brackets in front of it have closed.
		add_case(tts_pkg::MODE_WORD, 0, tts_pkg::CH_LBRACK, 40, tts_pkg::CH_RBRACK, 40,
			" and ", 0, 0, 0, 0, 0);
		add_case(tts_pkg::MODE_CMP, 0, 0, 0, 0, 0, "a==b", 1, 1, 1, tts_pkg::OP_EQ, 0);
		add_case(tts_pkg::MODE_CMP, 0, 0, 0, 0, 0, "a!=b", 1, 1, 1, tts_pkg::OP_NE, 0);
		add_case(tts_pkg::MODE_CMP, 0, 0, 0, 0, 0, "a<<b>=c", 1, 1, 4, tts_pkg::OP_GE, 0);
		add_case(tts_pkg::MODE_CMP, 0, 0, 0, 0, 0, "x<=y", 1, 1, 1, tts_pkg::OP_LE, 0);
		add_case(tts_pkg::MODE_CMP, 0, 0, 0, 0, 0, "x>y", 1, 1, 1, tts_pkg::OP_GT, 0);
		add_case(tts_pkg::MODE_CMP, 0, 0, 0, 0, 0, "'\\''<", 1, 1, 4, tts_pkg::OP_LT, 0);
		add_case(tts_pkg::MODE_CMP, 0, 0, 0, 0, 0, "[a<b]", 1, 0, 0, tts_pkg::OP_NONE, 0);
		add_case(tts_pkg::MODE_CMP, 0, 0, 0, 0, 0, "a=b", 1, 0, 0, tts_pkg::OP_NONE, 0);
		add_case(tts_pkg::MODE_CMP, 0, 0, 0, 0, 0, ">>", 1, 0, 0, tts_pkg::OP_NONE, 0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (text_cases[i]) begin
			if (text_cases[i].mode != cfg_mode || text_cases[i].ofs != cfg_ofs) begin
				settle();
				apply_setting(text_cases[i].mode, text_cases[i].ofs);
			end
			repeat (text_cases[i].n_a) add_ch(text_cases[i].fill_a);
			repeat (text_cases[i].n_b) add_ch(text_cases[i].fill_b);
			add_str(text_cases[i].text);
			last_q[last_q.size() - 1] = 1'b1;
			send_queued();
			if (text_cases[i].known)
				pending_results[pending_results.size() - 1] = text_cases[i].want;
		end

		rand_start = bytes_sent;
		while (bytes_sent - rand_start < RAND_BYTES) begin
			n_expr = $urandom_range(1, 4);
			first_len = 0;
			for (int e = 0; e < n_expr; e++) begin
				target = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 24);
				start = txt_q.size();
				while (txt_q.size() - start < target) add_token();
				last_q[last_q.size() - 1] = 1'b1;
				if (e == 0) first_len = txt_q.size();
			end
			mode = 2'($urandom_range(0, 3));
			lparens.delete();
			for (int i = 0; i < first_len; i++)
				if (txt_q[i] == tts_pkg::CH_LPAREN) lparens.push_back(i);
			r = $urandom_range(0, 19);
			// A close search mostly starts on one of the first text's open parens.
			if (mode == tts_pkg::MODE_CALL_CLOSE && r < 14 && lparens.size() != 0)
				ofs = 16'(lparens[$urandom_range(0, lparens.size() - 1)]);
			else if (r < 10) ofs = 16'd0;
			else if (r < 16) ofs = 16'($urandom_range(0, 12));
			else if (r < 19) ofs = 16'($urandom_range(0, 65535));
			else ofs = 16'hFFFF;
			settle();
			apply_setting(mode, ofs);
			send_queued();
		end

		settle();
		repeat (8) @(posedge clk);
		$display("Scanned %0d expressions (%0d bytes) over all four search modes;",
			expr_count, bytes_sent);
		$display("%0d of them matched, %0d result words checked, %0d mismatches.",
			hits_seen, results_seen, mismatches);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("ERROR run did not finish within %0d cycles", CYCLE_LIMIT);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

### filelist.f
hdl/tts_pkg.sv
hdl/tts_in_stage.sv
hdl/tts_scan.sv
hdl/tts_out_stage.sv
hdl/top_level_token_scanner.sv
tb/tb.sv
